### rtl/ped_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ped_pkg
// Types, character constants and helpers shared by the percent-escape decoder.
// ----------------------------------------------------------------------------
package ped_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;

	localparam int MAX_RESULTS = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_in;
	} enc_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_out;
	} dec_item_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	// results of one item, entry 0 first
	typedef struct packed {
		logic [1:0]                        cnt;
		dec_item_t [MAX_RESULTS-1:0]       res;
	} dec_bundle_t;

	function automatic logic hex_ok(input logic [7:0] c);
		return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
		       ((c >= CH_UPPER_A) && (c <= CH_UPPER_F));
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		if (c <= CH_NINE) begin
			d = c - CH_ZERO;
		end else begin
			d = c - CH_UPPER_A + 8'd10;
		end
		return d[3:0];
	endfunction

endpackage

### rtl/percent_escape_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percent_escape_decoder
// Streaming percent-escape decoder for names.
// ----------------------------------------------------------------------------
// Takes one encoded byte per cycle and gives one decoded byte per cycle while
// neither side stalls. An item enters an input register, is decoded against
// the escape state combinationally and lands in a three-entry result
// register. The result register hands out one byte per cycle unless the
// receiver stalls: an item that releases held bytes (a failed escape, or a
// flush on the last byte) produces one to three results and holds the input
// side until its last result is being taken; an escape prefix produces none.
// ----------------------------------------------------------------------------
module percent_escape_decoder
	import ped_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      enc_valid,
	output logic      enc_stall,
	input  enc_item_t enc_item,
	output logic      dec_valid,
	input  logic      dec_stall,
	output dec_item_t dec_item
);

	logic        valid_s1;
	enc_item_t   item_s1;
	logic        load_ok;
	logic        advance;
	dec_bundle_t bundle;

	assign advance   = valid_s1 && load_ok;
	assign enc_stall = valid_s1 && !load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!enc_stall) begin
			valid_s1 <= enc_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (enc_valid && !enc_stall) begin
			item_s1 <= enc_item;
		end
	end

	ped_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.advance (advance),
		.bundle  (bundle)
	);

	ped_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.bundle    (bundle),
		.load      (advance),
		.load_ok   (load_ok),
		.dec_valid (dec_valid),
		.dec_stall (dec_stall),
		.dec_item  (dec_item)
	);

endmodule

### rtl/ped_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ped_decode
// Escape state (phase and held digit) and the decode of one item into up to
// three result bytes.
// ----------------------------------------------------------------------------
module ped_decode
	import ped_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  enc_item_t   item,
	input  logic        advance,
	output dec_bundle_t bundle
);

	phase_t     phase_q, phase_d;
	logic [7:0] held_q, held_d;

	always_comb begin
		logic [7:0] b;
		logic       last;
		logic       fresh;
		logic [1:0] n;
		b      = item.in_byte;
		last   = item.last_in;
		fresh  = 1'b0;
		n      = 2'd0;
		phase_d = phase_q;
		held_d  = held_q;
		bundle  = '0;
		case (phase_q)
			PH_PCT: begin
				if (hex_ok(b)) begin
					if (last) begin
						bundle.res[0] = '{out_byte: CH_PERCENT, last_out: 1'b0};
						bundle.res[1] = '{out_byte: b, last_out: 1'b1};
						n = 2'd2;
						phase_d = PH_IDLE;
					end else begin
						held_d  = b;
						phase_d = PH_DIGIT;
					end
				end else begin
					bundle.res[0] = '{out_byte: CH_PERCENT, last_out: 1'b0};
					n = 2'd1;
					fresh = 1'b1;
				end
			end
			PH_DIGIT: begin
				if (hex_ok(b)) begin
					bundle.res[0] = '{out_byte: {hex_val(held_q), hex_val(b)}, last_out: last};
					n = 2'd1;
					phase_d = PH_IDLE;
				end else begin
					bundle.res[0] = '{out_byte: CH_PERCENT, last_out: 1'b0};
					bundle.res[1] = '{out_byte: held_q, last_out: 1'b0};
					n = 2'd2;
					fresh = 1'b1;
				end
			end
			default: begin
				fresh = 1'b1;
			end
		endcase
		if (fresh) begin
			if ((b == CH_PERCENT) && !last) begin
				phase_d = PH_PCT;
			end else begin
				bundle.res[n] = '{out_byte: b, last_out: last};
				n = n + 2'd1;
				phase_d = PH_IDLE;
			end
		end
		bundle.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

endmodule

### rtl/ped_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ped_outq
// Result register holding up to three decoded bytes of one item, handed out
// one per cycle from the head while dec_stall is low.
// ----------------------------------------------------------------------------
module ped_outq
	import ped_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dec_bundle_t bundle,
	input  logic        load,
	output logic        load_ok,
	output logic        dec_valid,
	input  logic        dec_stall,
	output dec_item_t   dec_item
);

	dec_item_t [MAX_RESULTS-1:0] res_q;
	logic [1:0]                  cnt_q;
	logic                        take;

	assign dec_valid = (cnt_q != 2'd0);
	assign dec_item  = res_q[0];
	assign take      = dec_valid && !dec_stall;
	assign load_ok   = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= bundle.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= bundle.res;
		end else if (take) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

endmodule

### dv/percent_escape_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percent_escape_decoder_tb
// Self-checking bench for the streaming percent-escape decoder.
// ----------------------------------------------------------------------------
// Encoded bytes go in through the valid/stall input channel. Each accepted item
// runs through a local escape decoder, which queues the decoded items it
// expects. Every decoded item that leaves the block is checked field by field
// against the oldest queued one. Directed names hit the byte extremes, good
// and broken escapes, lower-case digits and the flush on the last byte. Random
// names follow. The sender idles in bursts and the receiver stalls on a
// pattern of its own.
// ----------------------------------------------------------------------------
module percent_escape_decoder_tb;
	import ped_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      enc_valid = 1'b0;
	logic      enc_stall;
	enc_item_t enc_item = '0;
	logic      dec_valid;
	logic      dec_stall = 1'b0;
	dec_item_t dec_item;

	dec_item_t  decoded_q[$];
	phase_t     esc_phase = PH_IDLE;
	logic [7:0] esc_digit = 8'h00;

	int n_items = 0;
	int n_names = 0;
	int n_checked = 0;
	int n_fail = 0;
	int cycle_cnt = 0;
	int tx_gap_max = 0;
	int tx_burst_left = 0;
	int rx_mode = 0;
	int rx_left = 0;

	percent_escape_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.enc_valid (enc_valid),
		.enc_stall (enc_stall),
		.enc_item  (enc_item),
		.dec_valid (dec_valid),
		.dec_stall (dec_stall),
		.dec_item  (dec_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver stall pattern: free, sparse or heavy, switching on its own
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 2);
			rx_left <= $urandom_range(8, 40);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0: dec_stall <= 1'b0;
			1: dec_stall <= ($urandom_range(0, 3) == 0);
			default: dec_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin
		dec_item_t want;
		if (arst_n && dec_valid && !dec_stall) begin
			if (decoded_q.size() == 0) begin
				$error("unexpected decoded item: out_byte %h last_out %b",
				       dec_item.out_byte, dec_item.last_out);
				n_fail++;
			end else begin
				want = decoded_q.pop_front();
				n_checked++;
				if (dec_item.out_byte !== want.out_byte) begin
					$error("out_byte: expected %h, got %h", want.out_byte, dec_item.out_byte);
					n_fail++;
				end
				if (dec_item.last_out !== want.last_out) begin
					$error("last_out: expected %b, got %b", want.last_out, dec_item.last_out);
					n_fail++;
				end
			end
		end
	end

	function automatic logic is_hex_digit(input logic [7:0] c);
		return (c inside {[CH_ZERO:CH_NINE], [CH_UPPER_A:CH_UPPER_F]});
	endfunction

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		if (c >= CH_UPPER_A) begin
			return c[3:0] + 4'd9;
		end
		return c[3:0];
	endfunction

	// escape decoder: queues the decoded items one encoded item releases
	task automatic decode_byte(input logic [7:0] b, input logic last);
		logic fresh;
		fresh = 1'b1;
		case (esc_phase)
			PH_PCT: begin
				if (is_hex_digit(b)) begin
					if (last) begin
						decoded_q.push_back({CH_PERCENT, 1'b0});
						decoded_q.push_back({b, 1'b1});
						esc_phase = PH_IDLE;
					end else begin
						esc_digit = b;
						esc_phase = PH_DIGIT;
					end
					fresh = 1'b0;
				end else begin
					decoded_q.push_back({CH_PERCENT, 1'b0});
					esc_phase = PH_IDLE;
				end
			end
			PH_DIGIT: begin
				if (is_hex_digit(b)) begin
					decoded_q.push_back({hex_nibble(esc_digit), hex_nibble(b), last});
					fresh = 1'b0;
				end else begin
					decoded_q.push_back({CH_PERCENT, 1'b0});
					decoded_q.push_back({esc_digit, 1'b0});
				end
				esc_phase = PH_IDLE;
			end
			default: esc_phase = PH_IDLE;
		endcase
		if (fresh) begin
			if (b == CH_PERCENT && !last) begin
				esc_phase = PH_PCT;
			end else begin
				decoded_q.push_back({b, last});
			end
		end
	endtask

	task automatic send_enc(input logic [7:0] b, input logic last);
		enc_item_t it;
		int gap;
		if (tx_burst_left == 0) begin
			gap = $urandom_range(0, tx_gap_max);
			repeat (gap) begin
				@(negedge clk);
				enc_valid <= 1'b0;
			end
			tx_burst_left = $urandom_range(1, 12);
		end
		tx_burst_left--;
		it.in_byte = b;
		it.last_in = last;
		@(negedge clk);
		enc_valid <= 1'b1;
		enc_item <= it;
		@(posedge clk);
		while (enc_stall) begin
			@(posedge clk);
		end
		decode_byte(b, last);
		n_items++;
		if (last) begin
			n_names++;
		end
	endtask

	function automatic logic [7:0] rand_hex();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10) begin
			return CH_ZERO + 8'(v);
		end
		return CH_UPPER_A + 8'(v - 10);
	endfunction

	function automatic logic [7:0] rand_lower_hex();
		return 8'h61 + 8'($urandom_range(0, 5));
	endfunction

	function automatic logic [7:0] rand_plain();
		logic [7:0] b;
		b = 8'($urandom_range(1, 255));
		if (b == CH_PERCENT) begin
			b = 8'h2f;
		end
		return b;
	endfunction

	function automatic logic [7:0] rand_noise_byte();
		case ($urandom_range(0, 9))
			0, 1, 2: return CH_PERCENT;
			3, 4, 5: return rand_hex();
			6: return rand_lower_hex();
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	task automatic test_extremes();
		tx_gap_max = 0;
		send_enc(8'h01, 1'b0);
		send_enc(8'hff, 1'b0);
		send_enc(8'h00, 1'b1);
		send_enc(CH_PERCENT, 1'b0);
		send_enc(CH_ZERO, 1'b0);
		send_enc(CH_NINE, 1'b0);
		send_enc(CH_PERCENT, 1'b0);
		send_enc(CH_UPPER_F, 1'b0);
		send_enc(CH_UPPER_F, 1'b1);
	endtask

	task automatic test_escape_cases();
		tx_gap_max = 3;
		// lower-case digits do not form an escape
		send_enc(CH_PERCENT, 1'b0);
		send_enc(8'h61, 1'b0);
		send_enc(8'h66, 1'b0);
		// second digit is a new escape start
		send_enc(CH_PERCENT, 1'b0);
		send_enc(8'h34, 1'b0);
		send_enc(CH_PERCENT, 1'b0);
		send_enc(8'h34, 1'b0);
		send_enc(CH_UPPER_A - 8'h10, 1'b0);
		send_enc(8'h31, 1'b0);
		send_enc(8'h47, 1'b0);
	endtask

	task automatic test_flush_cases();
		tx_gap_max = 2;
		send_enc(CH_PERCENT, 1'b0);
		send_enc(8'h47, 1'b1);
		send_enc(CH_PERCENT, 1'b1);
		send_enc(CH_PERCENT, 1'b0);
		send_enc(CH_UPPER_A, 1'b1);
		send_enc(CH_PERCENT, 1'b0);
		send_enc(8'h37, 1'b0);
		send_enc(8'h7a, 1'b1);
	endtask

	task automatic test_random_names(input int count);
		logic [7:0] name_q[$];
		int stop_at;
		int tokens;
		stop_at = n_items + count;
		while (n_items < stop_at) begin
			name_q.delete();
			tokens = $urandom_range(1, 6);
			tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (tokens) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: begin
						name_q.push_back(CH_PERCENT);
						name_q.push_back(rand_hex());
						name_q.push_back(rand_hex());
					end
					5, 6: name_q.push_back(rand_plain());
					7: begin
						name_q.push_back(CH_PERCENT);
						name_q.push_back(($urandom_range(0, 1) == 0) ? rand_hex() : rand_lower_hex());
						name_q.push_back(rand_lower_hex());
					end
					8: begin
						name_q.push_back(CH_PERCENT);
						if ($urandom_range(0, 1) == 0) begin
							name_q.push_back(rand_hex());
						end
					end
					default: name_q.push_back(8'($urandom_range(1, 255)));
				endcase
			end
			foreach (name_q[i]) begin
				send_enc(name_q[i], i == name_q.size() - 1);
			end
		end
	endtask

	task automatic test_random_noise(input int count);
		repeat (count) begin
			tx_gap_max = $urandom_range(0, 4);
			send_enc(rand_noise_byte(), ($urandom_range(0, 5) == 0));
		end
		send_enc(rand_noise_byte(), 1'b1);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_extremes();
		test_escape_cases();
		test_flush_cases();
		test_random_names(220);
		test_random_noise(60);

		@(negedge clk);
		enc_valid <= 1'b0;
		while (decoded_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);

		$display("%0d encoded items sent in %0d names, %0d decoded items checked",
		         n_items, n_names, n_checked);
		$display("good, lower-case and broken escapes and last-byte flushes, random idling");
		if (n_fail == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
